// ===== sv/kdns_pkg.sv =====
`timescale 1ns / 1ps
// Package for the kd-tree neighbor search block: sizes, constants and
// coordinate helpers. It depends on nothing else.
package kdns_pkg;

  localparam int MAX_NODES_DEF   = 1024;
  localparam int MAX_DIMS_DEF    = 3;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int MAX_K_DEF       = 16;
  localparam int MAX_HITS_DEF    = 64;

  localparam int DW = 34;
  localparam logic [DW-1:0] SENTINEL_DIST = 34'd9999999;
  localparam logic signed [10:0] NO_NODE = -11'sd1;

  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_K      = 3'd1;
  localparam logic [2:0] CFG_RADIUS = 3'd2;
  localparam logic [2:0] CFG_ROOT   = 3'd3;
  localparam logic [2:0] CFG_DIMS   = 3'd4;

  localparam logic CMD_WRITE = 1'b0;

  function automatic logic signed [15:0] coord_sel(input logic [47:0] pt,
                                                   input logic [1:0] ax);
    logic signed [15:0] c;
    case (ax)
      2'd0:    c = pt[15:0];
      2'd1:    c = pt[31:16];
      default: c = pt[47:32];
    endcase
    return c;
  endfunction

  function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
                                           input logic signed [15:0] b);
    logic signed [16:0] d;
    logic [16:0] m;
    d = {a[15], a} - {b[15], b};
    m = d[16] ? 17'(-d) : d;
    return m[15:0];
  endfunction

endpackage

// ===== sv/kdns_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// It depends on nothing else.
module kdns_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== sv/kd_tree_neighbor_search.sv =====
`timescale 1ns / 1ps
// Top level of the kd-tree neighbor search block with its sequencer.
// It depends on kdns_pkg and kdns_ram.
//
// Usage: the input channel carries requests with valid and ready. A write
// request (cmd 0) stores one tree node. A query request (cmd 1) walks the
// tree from the root register; ready stays low until the last result of
// that query has been taken. Results leave on the output channel with valid
// and ready, one node index per result, last marking the final one and
// overflow repeated on each. Registers are written through a plain write
// port; the user must write them only while no query is in flight, which
// the block itself does not enforce. Each descent step reads the node
// memory; each popped node is read, then its squared distance is summed
// axis by axis through the single shared multiplier, which also squares
// the radius. A receiver stall simply holds the result register. Reset
// empties all working lists and loads the register defaults; the node
// memories are undefined until written.
module kd_tree_neighbor_search
  import kdns_pkg::*;
#(
  parameter int MAX_NODES   = kdns_pkg::MAX_NODES_DEF,
  parameter int MAX_DIMS    = kdns_pkg::MAX_DIMS_DEF,
  parameter int STACK_DEPTH = kdns_pkg::STACK_DEPTH_DEF,
  parameter int MAX_K       = kdns_pkg::MAX_K_DEF,
  parameter int MAX_HITS    = kdns_pkg::MAX_HITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [9:0]         node_slot_i,
  input  logic signed [15:0] coord_a_i,
  input  logic signed [15:0] coord_b_i,
  input  logic signed [15:0] coord_c_i,
  input  logic [1:0]         split_axis_i,
  input  logic signed [10:0] left_child_i,
  input  logic signed [10:0] right_child_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [10:0] neighbor_index_o,
  output logic               last_o,
  output logic               overflow_o
);
  import kdns_pkg::*;

  localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int VW  = $clog2(MAX_NODES + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int HAW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int HCW = $clog2(MAX_HITS + 1);
  localparam int KIW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int KCW = $clog2(MAX_K + 1);
  localparam logic [1:0] AX_MAX = 2'(MAX_DIMS - 1);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_SETUP = 15'b000000000000010,
    S_DESC  = 15'b000000000000100,
    S_DRD   = 15'b000000000001000,
    S_POP   = 15'b000000000010000,
    S_PRD   = 15'b000000000100000,
    S_NRD   = 15'b000000001000000,
    S_DSQ   = 15'b000000010000000,
    S_DACC  = 15'b000000100000000,
    S_UPD   = 15'b000001000000000,
    S_PSQ   = 15'b000010000000000,
    S_PCHK  = 15'b000100000000000,
    S_EMIT  = 15'b001000000000000,
    S_ERD   = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  logic              mode_q;
  logic [4:0]        kreg_q;
  logic [15:0]       radius_q;
  logic signed [10:0] root_q;
  logic [1:0]        dims_reg_q;

  logic [47:0]       qpt_q;
  logic [1:0]        dims_q, i_q;
  logic [KCW-1:0]    kk_q;
  logic [DW-1:0]     r2_q, sq_q, acc_q;
  logic signed [10:0] cur_q;
  logic [SCW-1:0]    scnt_q;
  logic [HCW-1:0]    hcnt_q, hout_q;
  logic [VW-1:0]     visits_q;
  logic              ovf_q;
  logic [NW-1:0]     node_q;
  logic [47:0]       pt_q;
  logic [23:0]       lk_q;
  logic [KCW-1:0]    bcnt_q, ek_q;
  logic [DW-1:0]     bdist_q [MAX_K];
  logic signed [10:0] bidx_q [MAX_K];
  logic signed [10:0] oidx_q;
  logic              olast_q, ovalid_q;

  logic [47:0] pt_rd;
  logic [23:0] lk_rd;
  logic [NW-1:0] stk_rd, hit_rd;
  logic [NW-1:0] node_raddr;
  logic in_acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      kreg_q     <= 5'd1;
      radius_q   <= '0;
      root_q     <= NO_NODE;
      dims_reg_q <= 2'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:   mode_q     <= cfg_data_i[0];
        CFG_K:      kreg_q     <= cfg_data_i[4:0];
        CFG_RADIUS: radius_q   <= cfg_data_i;
        CFG_ROOT:   root_q     <= cfg_data_i[10:0];
        CFG_DIMS:   dims_reg_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  function automatic logic present(input logic signed [10:0] c);
    return !c[10] && (32'(c[9:0]) < MAX_NODES);
  endfunction

  function automatic logic [1:0] clamp_ax(input logic [1:0] a);
    return (a > AX_MAX) ? AX_MAX : a;
  endfunction

  // Memories.
  logic node_we;
  assign node_we = in_acc && (cmd_i == CMD_WRITE) && (32'(node_slot_i) < MAX_NODES);
  assign node_raddr = (state_q == S_PRD) ? stk_rd : NW'(cur_q[9:0]);

  kdns_ram #(.W(48), .D(MAX_NODES)) u_points (
    .clk_i, .we_i(node_we), .waddr_i(NW'(node_slot_i)),
    .wdata_i({coord_c_i, coord_b_i, coord_a_i}),
    .raddr_i(node_raddr), .rdata_o(pt_rd)
  );

  kdns_ram #(.W(24), .D(MAX_NODES)) u_links (
    .clk_i, .we_i(node_we), .waddr_i(NW'(node_slot_i)),
    .wdata_i({right_child_i, left_child_i, split_axis_i}),
    .raddr_i(node_raddr), .rdata_o(lk_rd)
  );

  logic [SCW-1:0] scnt_dec;
  logic stk_we;
  assign scnt_dec = scnt_q - SCW'(1);
  assign stk_we = (state_q == S_DRD) && (scnt_q != SCW'(STACK_DEPTH));

  kdns_ram #(.W(NW), .D(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(scnt_q[SAW-1:0]), .wdata_i(NW'(cur_q[9:0])),
    .raddr_i(scnt_dec[SAW-1:0]), .rdata_o(stk_rd)
  );

  logic [HCW-1:0] hout_dec;
  logic hit_we, is_hit;
  assign hout_dec = hout_q - HCW'(1);
  assign is_hit = (acc_q < r2_q);
  assign hit_we = (state_q == S_UPD) && mode_q && is_hit && (hcnt_q != HCW'(MAX_HITS));

  kdns_ram #(.W(NW), .D(1 << HAW)) u_hits (
    .clk_i, .we_i(hit_we), .waddr_i(hcnt_q[HAW-1:0]), .wdata_i(node_q),
    .raddr_i(hout_dec[HAW-1:0]), .rdata_o(hit_rd)
  );

  // Shared squaring unit and node fields.
  logic [1:0]  ax_n, sel_ax;
  logic [15:0] mul_op;
  logic [DW-1:0] prod;
  logic signed [15:0] q_ax, n_ax;
  logic signed [10:0] lc, rc, far_c;
  logic [KCW-1:0] blast;
  logic [DW-1:0] bound;

  assign ax_n   = clamp_ax(lk_q[1:0]);
  assign sel_ax = (state_q == S_PSQ) ? ax_n : i_q;
  assign mul_op = (state_q == S_SETUP) ? radius_q
                : abs_diff(coord_sel(qpt_q, sel_ax), coord_sel(pt_q, sel_ax));
  assign prod   = DW'(32'(mul_op) * 32'(mul_op));
  assign q_ax   = coord_sel(qpt_q, ax_n);
  assign n_ax   = coord_sel(pt_q, ax_n);
  assign lc     = lk_q[12:2];
  assign rc     = lk_q[23:13];
  assign far_c  = (q_ax > n_ax) ? lc : rc;
  assign blast  = bcnt_q - KCW'(1);
  assign bound  = mode_q ? r2_q : bdist_q[blast[KIW-1:0]];

  // Sorted insertion into the best list.
  logic [MAX_K-1:0] le;
  logic do_ins;
  always_comb begin
    for (int j = 0; j < MAX_K; j++) begin
      le[j] = (KCW'(j) < bcnt_q) && (bdist_q[j] <= acc_q);
    end
  end
  assign do_ins = (bcnt_q < kk_q) || (acc_q < bdist_q[blast[KIW-1:0]]);

  // Sequencer.
  logic [1:0] dims_cfg;
  logic [KCW-1:0] kk_cfg;
  logic [1:0] ax_d;
  always_comb begin
    dims_cfg = (dims_reg_q == 2'd0) ? 2'd1 : dims_reg_q;
    if (32'(dims_cfg) > MAX_DIMS) dims_cfg = 2'(MAX_DIMS);
    if (kreg_q == 5'd0) kk_cfg = KCW'(1);
    else if (32'(kreg_q) > MAX_K) kk_cfg = KCW'(MAX_K);
    else kk_cfg = KCW'(kreg_q);
    ax_d = clamp_ax(lk_rd[1:0]);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc && cmd_i != CMD_WRITE) state_d = S_SETUP;
      S_SETUP: state_d = S_DESC;
      S_DESC:  state_d = present(cur_q) ? S_DRD : S_POP;
      S_DRD:   state_d = (scnt_q == SCW'(STACK_DEPTH)) ? S_POP : S_DESC;
      S_POP: begin
        if (scnt_q == '0 || visits_q >= VW'(MAX_NODES)) state_d = S_EMIT;
        else state_d = S_PRD;
      end
      S_PRD:   state_d = S_NRD;
      S_NRD:   state_d = S_DSQ;
      S_DSQ:   state_d = S_DACC;
      S_DACC:  state_d = (i_q + 2'd1 == dims_q) ? S_UPD : S_DSQ;
      S_UPD:   state_d = S_PSQ;
      S_PSQ:   state_d = S_PCHK;
      S_PCHK:  state_d = (present(far_c) && sq_q < bound) ? S_DESC : S_POP;
      S_EMIT:  state_d = (mode_q && hout_q != '0) ? S_ERD : S_OUT;
      S_ERD:   state_d = S_OUT;
      S_OUT: begin
        if (out_ready_i) state_d = olast_q ? S_IDLE : S_EMIT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      scnt_q   <= '0;
      hcnt_q   <= '0;
      hout_q   <= '0;
      bcnt_q   <= '0;
      ek_q     <= '0;
      visits_q <= '0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
      i_q      <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (in_acc && cmd_i != CMD_WRITE) begin
            scnt_q   <= '0;
            hcnt_q   <= '0;
            bcnt_q   <= KCW'(1);
            ek_q     <= '0;
            visits_q <= '0;
            ovf_q    <= 1'b0;
          end
        end
        S_DRD: begin
          if (scnt_q == SCW'(STACK_DEPTH)) ovf_q <= 1'b1;
          else scnt_q <= scnt_q + SCW'(1);
        end
        S_POP: begin
          if (scnt_q == '0) begin
            hout_q <= hcnt_q;
          end else if (visits_q >= VW'(MAX_NODES)) begin
            ovf_q  <= 1'b1;
            hout_q <= hcnt_q;
          end else begin
            visits_q <= visits_q + VW'(1);
            scnt_q   <= scnt_dec;
          end
        end
        S_NRD:  i_q <= '0;
        S_DACC: i_q <= i_q + 2'd1;
        S_UPD: begin
          if (mode_q) begin
            if (is_hit) begin
              if (hcnt_q != HCW'(MAX_HITS)) hcnt_q <= hcnt_q + HCW'(1);
              else ovf_q <= 1'b1;
            end
          end else if (do_ins && bcnt_q < kk_q) begin
            bcnt_q <= bcnt_q + KCW'(1);
          end
        end
        S_EMIT: ovalid_q <= !(mode_q && hout_q != '0);
        S_ERD: begin
          ovalid_q <= 1'b1;
          hout_q   <= hout_dec;
        end
        S_OUT: begin
          if (out_ready_i) begin
            ovalid_q <= 1'b0;
            ek_q     <= ek_q + KCW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        qpt_q  <= {coord_c_i, coord_b_i, coord_a_i};
        dims_q <= dims_cfg;
        kk_q   <= kk_cfg;
        cur_q  <= root_q;
        bdist_q[0] <= SENTINEL_DIST;
        bidx_q[0]  <= NO_NODE;
      end
      S_SETUP: r2_q <= prod;
      S_DRD: begin
        cur_q <= (coord_sel(qpt_q, ax_d) <= coord_sel(pt_rd, ax_d))
                 ? lk_rd[12:2] : lk_rd[23:13];
      end
      S_PRD: node_q <= stk_rd;
      S_NRD: begin
        pt_q  <= pt_rd;
        lk_q  <= lk_rd;
        acc_q <= '0;
      end
      S_DSQ:  sq_q <= prod;
      S_DACC: acc_q <= acc_q + sq_q;
      S_UPD: begin
        if (!mode_q && do_ins) begin
          for (int j = 0; j < MAX_K; j++) begin
            if (!le[j]) begin
              if (j == 0 || le[(j > 0) ? j - 1 : 0]) begin
                bdist_q[j] <= acc_q;
                bidx_q[j]  <= 11'(node_q);
              end else begin
                bdist_q[j] <= bdist_q[(j > 0) ? j - 1 : 0];
                bidx_q[j]  <= bidx_q[(j > 0) ? j - 1 : 0];
              end
            end
          end
        end
      end
      S_PSQ:  sq_q <= prod;
      S_PCHK: cur_q <= far_c;
      S_EMIT: begin
        if (mode_q) begin
          oidx_q  <= NO_NODE;
          olast_q <= 1'b1;
        end else begin
          oidx_q  <= bidx_q[ek_q[KIW-1:0]];
          olast_q <= (ek_q == blast);
        end
      end
      S_ERD: begin
        oidx_q  <= 11'(hit_rd);
        olast_q <= (hout_q == HCW'(1));
      end
      default: ;
    endcase
  end

  assign out_valid_o      = ovalid_q;
  assign neighbor_index_o = oidx_q;
  assign last_o           = olast_q;
  assign overflow_o       = ovf_q;

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scnt_q <= SCW'(STACK_DEPTH)) else $error("path stack count past depth");
  a_hits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q <= HCW'(MAX_HITS)) else $error("hit count past capacity");
  a_best_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_SETUP) |-> (bcnt_q != '0 && bcnt_q <= kk_q))
    else $error("best list count out of range");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("result pending while ready");
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> in_ready_o)
    else $error("block not ready after final result");
endmodule

// ===== bench/kdns_checker.sv =====
`timescale 1ns / 1ps
// Checker for the kd-tree neighbor search block: it watches the register port, the
// request and result channels, predicts the results and compares them. Uses kdns_pkg.
module kdns_checker
  import kdns_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               cmd_i,
  input  logic [9:0]         node_slot_i,
  input  logic signed [15:0] coord_a_i,
  input  logic signed [15:0] coord_b_i,
  input  logic signed [15:0] coord_c_i,
  input  logic [1:0]         split_axis_i,
  input  logic signed [10:0] left_child_i,
  input  logic signed [10:0] right_child_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [10:0] neighbor_index_i,
  input  logic               last_i,
  input  logic               overflow_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct {
    logic signed [10:0] idx;
    logic               last;
    logic               ovf;
  } nbr_result_t;

  nbr_result_t expected_q[$];

  logic [47:0] node_pt [1024];
  logic [23:0] node_ln [1024];

  logic               mode_r;
  logic [4:0]         k_r;
  logic [15:0]        radius_r;
  logic signed [10:0] root_r;
  logic [1:0]         dims_r;

  int                 path_stk [64];
  int                 path_sp;
  int                 hit_buf [64];
  int                 hit_cnt;
  int                 best_idx [17];
  longint unsigned    best_d [17];
  int                 best_cnt;
  logic               walk_ovf;
  int                 qv [3];

  function automatic bit present(int n);
    return n >= 0 && n < MAX_NODES_DEF;
  endfunction

  function automatic int coord_at(int n, int ax);
    logic signed [15:0] c;
    c = node_pt[n][16*ax +: 16];
    return c;
  endfunction

  function automatic int axis_at(int n);
    int a;
    a = node_ln[n][1:0];
    return (a > 2) ? 2 : a;
  endfunction

  function automatic int left_at(int n);
    logic signed [10:0] v;
    v = node_ln[n][12:2];
    return v;
  endfunction

  function automatic int right_at(int n);
    logic signed [10:0] v;
    v = node_ln[n][23:13];
    return v;
  endfunction

  function automatic longint unsigned sq_gap(int a, int b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return longint'(d * d);
  endfunction

  task automatic push_path(int start);
    int n;
    n = start;
    while (present(n)) begin
      if (path_sp >= STACK_DEPTH_DEF) begin
        walk_ovf = 1'b1;
        return;
      end
      path_stk[path_sp] = n;
      path_sp++;
      n = (qv[axis_at(n)] <= coord_at(n, axis_at(n))) ? left_at(n) : right_at(n);
    end
  endtask

  task automatic best_insert(int idx, longint unsigned d);
    int pos;
    pos = best_cnt;
    while (pos > 0 && best_d[pos-1] > d) begin
      best_d[pos] = best_d[pos-1];
      best_idx[pos] = best_idx[pos-1];
      pos--;
    end
    best_d[pos] = d;
    best_idx[pos] = idx;
    best_cnt++;
  endtask

  task automatic predict_neighbors(logic signed [15:0] qa, logic signed [15:0] qb,
                                   logic signed [15:0] qc);
    int dims, kk, visits, n, ax, nc, sib;
    longint unsigned r2, d, bound;
    nbr_result_t res;
    qv[0] = qa;
    qv[1] = qb;
    qv[2] = qc;
    dims = (dims_r == 0) ? 1 : dims_r;
    kk = (k_r == 0) ? 1 : ((k_r > MAX_K_DEF) ? MAX_K_DEF : k_r);
    r2 = longint'(radius_r) * longint'(radius_r);
    path_sp = 0;
    hit_cnt = 0;
    walk_ovf = 1'b0;
    best_cnt = 0;
    best_insert(-1, longint'(SENTINEL_DIST));
    push_path(root_r);
    visits = 0;
    while (path_sp > 0) begin
      if (visits >= MAX_NODES_DEF) begin
        walk_ovf = 1'b1;
        break;
      end
      visits++;
      path_sp--;
      n = path_stk[path_sp];
      d = 0;
      for (int i = 0; i < dims; i++) d += sq_gap(qv[i], coord_at(n, i));
      if (mode_r) begin
        if (d < r2) begin
          if (hit_cnt < MAX_HITS_DEF) begin
            hit_buf[hit_cnt] = n;
            hit_cnt++;
          end else begin
            walk_ovf = 1'b1;
          end
        end
        bound = r2;
      end else begin
        if (best_cnt < kk) begin
          best_insert(n, d);
        end else if (d < best_d[best_cnt-1]) begin
          best_cnt--;
          best_insert(n, d);
        end
        bound = best_d[best_cnt-1];
      end
      ax = axis_at(n);
      nc = coord_at(n, ax);
      sib = (qv[ax] > nc) ? left_at(n) : right_at(n);
      if (present(sib) && sq_gap(qv[ax], nc) < bound) push_path(sib);
    end
    if (mode_r) begin
      if (hit_cnt == 0) begin
        res.idx = -11'sd1;
        res.last = 1'b1;
        res.ovf = walk_ovf;
        expected_q.push_back(res);
      end
      for (int i = hit_cnt; i > 0; i--) begin
        res.idx = 11'(hit_buf[i-1]);
        res.last = (i == 1);
        res.ovf = walk_ovf;
        expected_q.push_back(res);
      end
    end else begin
      for (int i = 0; i < best_cnt; i++) begin
        res.idx = 11'(best_idx[i]);
        res.last = (i + 1 == best_cnt);
        res.ovf = walk_ovf;
        expected_q.push_back(res);
      end
    end
  endtask

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    nbr_result_t want;
    if (!rst_ni) begin
      expected_q.delete();
      mode_r <= 1'b0;
      k_r <= 5'd1;
      radius_r <= 16'd0;
      root_r <= NO_NODE;
      dims_r <= 2'd3;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result index %0d", neighbor_index_i));
        end else begin
          want = expected_q.pop_front();
          if (neighbor_index_i !== want.idx)
            report_mismatch($sformatf("neighbor_index %0d, expected %0d",
                                      neighbor_index_i, want.idx));
          if (last_i !== want.last)
            report_mismatch($sformatf("last %b, expected %b", last_i, want.last));
          if (overflow_i !== want.ovf)
            report_mismatch($sformatf("overflow %b, expected %b", overflow_i, want.ovf));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (cmd_i == CMD_WRITE) begin
          node_pt[node_slot_i] = {coord_c_i, coord_b_i, coord_a_i};
          node_ln[node_slot_i] = {right_child_i, left_child_i, split_axis_i};
        end else begin
          predict_neighbors(coord_a_i, coord_b_i, coord_c_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:   mode_r <= cfg_data_i[0];
          CFG_K:      k_r <= cfg_data_i[4:0];
          CFG_RADIUS: radius_r <= cfg_data_i;
          CFG_ROOT:   root_r <= cfg_data_i[10:0];
          CFG_DIMS:   dims_r <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== bench/tb_kd_tree_neighbor_search.sv =====
`timescale 1ns / 1ps
// Top of the kd-tree neighbor search testbench: clock, reset, node and query requests,
// register writes, watchdog and verdict. Depends on kdns_pkg, kdns_checker and the block.
module tb_kd_tree_neighbor_search;
  import kdns_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int MAX_TREE = 96;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               cmd_i = 1'b0;
  logic [9:0]         node_slot_i = '0;
  logic signed [15:0] coord_a_i = '0;
  logic signed [15:0] coord_b_i = '0;
  logic signed [15:0] coord_c_i = '0;
  logic [1:0]         split_axis_i = '0;
  logic signed [10:0] left_child_i = '0;
  logic signed [10:0] right_child_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [10:0] neighbor_index_o;
  logic               last_o;
  logic               overflow_o;
  int                 fail_count;
  int                 pending;

  int snd_idle = 0;
  int rcv_idle = 0;
  int items_sent = 0;
  int stall_cycles = 0;

  int          t_slot [MAX_TREE];
  logic [15:0] t_crd [MAX_TREE][3];
  logic [1:0]  t_ax [MAX_TREE];
  int          t_left [MAX_TREE];
  int          t_right [MAX_TREE];
  bit          slot_taken [1024];
  int          spread;

  always #1 clk_i = ~clk_i;

  kd_tree_neighbor_search dut (.*);

  kdns_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .node_slot_i,
    .coord_a_i, .coord_b_i, .coord_c_i, .split_axis_i, .left_child_i, .right_child_i,
    .out_valid_i(out_valid_o), .out_ready_i, .neighbor_index_i(neighbor_index_o),
    .last_i(last_o), .overflow_i(overflow_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= rcv_idle);

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_request(logic cmd, logic [9:0] slot, logic [15:0] ca, logic [15:0] cb,
                              logic [15:0] cc, logic [1:0] ax, logic [10:0] lc,
                              logic [10:0] rc);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i = cmd;
    node_slot_i = slot;
    coord_a_i = ca;
    coord_b_i = cb;
    coord_c_i = cc;
    split_axis_i = ax;
    left_child_i = lc;
    right_child_i = rc;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_query(logic [15:0] ca, logic [15:0] cb, logic [15:0] cc);
    send_request(1'b1, 10'($urandom), ca, cb, cc, 2'($urandom), 11'($urandom), 11'($urandom));
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_coord();
    if (spread == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic logic [10:0] link_code(int t, int n);
    if ($urandom_range(99) < 2) return 11'(t_slot[$urandom_range(0, n - 1)]);
    if (t >= 0) return 11'(t_slot[t]);
    if ($urandom_range(3) == 0) return 11'(-int'($urandom_range(1, 1024)));
    return NO_NODE;
  endfunction

  task automatic build_tree(int n);
    int cur, ax;
    bit placed;
    foreach (slot_taken[i]) slot_taken[i] = 1'b0;
    for (int i = 0; i < n; i++) begin
      do t_slot[i] = $urandom_range(0, 1023); while (slot_taken[t_slot[i]]);
      slot_taken[t_slot[i]] = 1'b1;
      for (int a = 0; a < 3; a++) t_crd[i][a] = rand_coord();
      t_ax[i] = 2'($urandom);
      t_left[i] = -1;
      t_right[i] = -1;
      cur = 0;
      placed = (i == 0);
      while (!placed) begin
        ax = (t_ax[cur] > 2) ? 2 : t_ax[cur];
        if ($signed(t_crd[i][ax]) <= $signed(t_crd[cur][ax])) begin
          if (t_left[cur] < 0) begin
            t_left[cur] = i;
            placed = 1'b1;
          end else cur = t_left[cur];
        end else begin
          if (t_right[cur] < 0) begin
            t_right[cur] = i;
            placed = 1'b1;
          end else cur = t_right[cur];
        end
      end
    end
    for (int i = 0; i < n; i++)
      send_request(CMD_WRITE, 10'(t_slot[i]), t_crd[i][0], t_crd[i][1], t_crd[i][2],
                   t_ax[i], link_code(t_left[i], n), link_code(t_right[i], n));
  endtask

  task automatic random_round();
    int n, pick, nq;
    logic [15:0] radius;
    spread = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 16 : 2048);
    n = ($urandom_range(4) == 0) ? $urandom_range(17, 90) : $urandom_range(1, 16);
    build_tree(n);
    wait_idle();
    pick = $urandom_range(3);
    radius = (pick == 0) ? 16'hFFFF : ((pick == 1) ? 16'd0 : 16'($urandom_range(0, 3000)));
    write_reg(CFG_MODE, 16'($urandom_range(1)));
    write_reg(CFG_K, 16'($urandom_range(0, 31)));
    write_reg(CFG_RADIUS, radius);
    write_reg(CFG_DIMS, 16'($urandom_range(0, 3)));
    if ($urandom_range(9) == 0)
      write_reg(CFG_ROOT, 16'(-int'($urandom_range(1, 1024))));
    else
      write_reg(CFG_ROOT, 16'(t_slot[0]));
    nq = $urandom_range(2, 8);
    for (int i = 0; i < nq; i++) begin
      if ($urandom_range(1) == 0) begin
        pick = $urandom_range(0, n - 1);
        send_query(t_crd[pick][0] + 16'($urandom_range(0, 6)) - 16'd3,
                   t_crd[pick][1], t_crd[pick][2]);
      end else begin
        send_query(rand_coord(), rand_coord(), rand_coord());
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_query(16'd0, 16'd0, 16'd0);
    wait_idle();
    write_reg(CFG_MODE, 16'd1);
    write_reg(CFG_ROOT, 16'h07F9);
    send_query(16'd5, 16'd5, 16'd5);
    send_request(CMD_WRITE, 10'd0, 16'd0, 16'd0, 16'd0, 2'd0, 11'd1023, 11'd2);
    send_request(CMD_WRITE, 10'd1023, 16'h8000, 16'h8000, 16'h8000, 2'd3,
                 NO_NODE, -11'sd1024);
    send_request(CMD_WRITE, 10'd2, 16'h7FFF, 16'h7FFF, 16'h7FFF, 2'd1, NO_NODE, 11'd3);
    send_request(CMD_WRITE, 10'd3, 16'h0100, 16'h7FFF, 16'hFF00, 2'd2, NO_NODE, NO_NODE);
    wait_idle();
    write_reg(CFG_MODE, 16'd0);
    write_reg(CFG_K, 16'd0);
    write_reg(CFG_DIMS, 16'd0);
    write_reg(CFG_ROOT, 16'd0);
    send_query(16'd0, 16'd0, 16'd0);
    send_query(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_query(16'h8000, 16'h8000, 16'h8000);
    wait_idle();
    write_reg(CFG_K, 16'd31);
    write_reg(CFG_DIMS, 16'd3);
    send_query(16'h0100, 16'h7FFF, 16'hFF00);
    wait_idle();
    write_reg(CFG_K, 16'd16);
    write_reg(CFG_ROOT, 16'd1023);
    send_query(16'h8000, 16'h0000, 16'h7FFF);
    wait_idle();
    write_reg(CFG_MODE, 16'd1);
    write_reg(CFG_ROOT, 16'd0);
    write_reg(CFG_RADIUS, 16'd0);
    send_query(16'd0, 16'd0, 16'd0);
    wait_idle();
    write_reg(CFG_RADIUS, 16'hFFFF);
    send_query(16'd0, 16'd0, 16'd0);
    send_request(CMD_WRITE, 10'd5, 16'd0, 16'd0, 16'd0, 2'd0, 11'd5, 11'd5);
    wait_idle();
    write_reg(CFG_ROOT, 16'd5);
    send_query(16'd0, 16'd0, 16'd0);
    wait_idle();
    write_reg(CFG_MODE, 16'd0);
    write_reg(CFG_K, 16'd2);
    send_query(16'd0, 16'd0, 16'd0);
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      snd_idle = (phase == 0) ? 11 : ((phase == 1) ? 61 : 0);
      rcv_idle = (phase == 0) ? 61 : ((phase == 1) ? 11 : 0);
      items_sent = 0;
      while (items_sent < 140) random_round();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
